// ===== src/bps_pkg.sv =====
// Shared types and constants for the beep pattern sequencer.
`default_nettype none

package bps_pkg;

  localparam int unsigned OUT_W     = 32;  // width of the reported tick counters
  localparam int unsigned DIV_W     = 4;   // divide phase counter width
  localparam int unsigned PHASE_W   = 16;  // phase length width
  localparam int unsigned BEEP_W    = 8;   // beep repeat count width
  localparam int unsigned CFG_W     = 16;  // widest configuration register
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd2;

  localparam logic [BEEP_W-1:0] ENDLESS_REPEAT = 8'd255;
  localparam logic [BEEP_W-1:0] REPEAT_RESET   = 8'd1;

  // Command flags of one accepted tick.
  typedef struct packed {
    logic accept;
    logic start;
    logic stop;
    logic clear;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/bps_tick_div.sv =====
// Millisecond counter, tick divider and divided counter.
`default_nettype none

module bps_tick_div import bps_pkg::*; #(
  parameter int unsigned TICK_DIVIDE = 10,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output logic                  div_tick_o,
  output logic [OUT_W-1:0]      ms_count_o,
  output logic [OUT_W-1:0]      tens_count_o
);

  localparam logic [DIV_W-1:0] DivLast = DIV_W'(TICK_DIVIDE);

  logic [COUNT_WIDTH-1:0] ms_q, ms_d;
  logic [COUNT_WIDTH-1:0] tens_q, tens_d;
  logic [DIV_W-1:0]       phase_q, phase_d;
  logic [DIV_W-1:0]       phase_inc;
  logic [COUNT_WIDTH-1:0] ms_base, tens_base;

  assign phase_inc  = phase_q + DIV_W'(1);
  assign div_tick_o = (phase_inc >= DivLast);

  always_comb begin
    ms_base   = cmd_i.clear ? '0 : ms_q;
    tens_base = cmd_i.clear ? '0 : tens_q;
    ms_d      = ms_base + COUNT_WIDTH'(1);
    tens_d    = div_tick_o ? tens_base + COUNT_WIDTH'(1) : tens_base;
    phase_d   = div_tick_o ? '0 : phase_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q    <= '0;
      tens_q  <= '0;
      phase_q <= '0;
    end else if (cmd_i.accept) begin
      ms_q    <= ms_d;
      tens_q  <= tens_d;
      phase_q <= phase_d;
    end
  end

  // Report the low bits, zero-extended for narrow counters.
  if (COUNT_WIDTH >= OUT_W) begin : g_wide
    assign ms_count_o   = ms_q[OUT_W-1:0];
    assign tens_count_o = tens_q[OUT_W-1:0];
  end else begin : g_narrow
    assign ms_count_o   = {{(OUT_W-COUNT_WIDTH){1'b0}}, ms_q};
    assign tens_count_o = {{(OUT_W-COUNT_WIDTH){1'b0}}, tens_q};
  end

endmodule

`default_nettype wire

// ===== src/bps_pattern.sv =====
// Configuration registers and beep pattern state machine.
`default_nettype none

module bps_pattern import bps_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire cmd_t                 cmd_i,
  input  wire logic                 div_tick_i,
  output logic                      tone_on_o,
  output logic                      playing_o
);

  logic [PHASE_W-1:0] play_q, pause_q;
  logic [BEEP_W-1:0]  repeat_q;

  logic [PHASE_W-1:0] remain_q, remain_d;
  logic [BEEP_W-1:0]  beeps_q, beeps_d;
  logic               active_q, active_d;
  logic               tone_q, tone_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q   <= '0;
      pause_q  <= '0;
      repeat_q <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLAY_TICKS:   play_q   <= cfg_data_i;
        CFG_PAUSE_TICKS:  pause_q  <= cfg_data_i;
        CFG_REPEAT_COUNT: repeat_q <= cfg_data_i[BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    remain_d = remain_q;
    beeps_d  = beeps_q;
    active_d = active_q;
    tone_d   = tone_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      beeps_d  = repeat_q;
      remain_d = '0;
      tone_d   = 1'b0;
    end
    if (cmd_i.stop) begin
      active_d = 1'b0;
      tone_d   = 1'b0;
    end
    if (div_tick_i && active_d) begin
      if (remain_d != '0) begin
        remain_d = remain_d - PHASE_W'(1);
      end else if (tone_d) begin
        // End of a tone phase: count the beep unless endless.
        if (beeps_d != ENDLESS_REPEAT) begin
          if (beeps_d != '0) beeps_d = beeps_d - BEEP_W'(1);
          if (beeps_d == '0) begin
            active_d = 1'b0;
            tone_d   = 1'b0;
          end
        end
        if (pause_q != '0) begin
          remain_d = pause_q;
          tone_d   = 1'b0;
        end else begin
          remain_d = play_q;
        end
      end else begin
        remain_d = play_q;
        tone_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      beeps_q  <= '0;
      active_q <= 1'b0;
      tone_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      remain_q <= remain_d;
      beeps_q  <= beeps_d;
      active_q <= active_d;
      tone_q   <= tone_d;
    end
  end

  assign tone_on_o = tone_q;
  assign playing_o = active_q;

endmodule

`default_nettype wire

// ===== src/beep_pattern_sequencer_unit.sv =====
// Top level of the beep pattern sequencer.
//
// Each input transaction is one millisecond tick carrying start, stop and
// clear flags; each produces exactly one output transaction with the
// millisecond count, the divided count, the tone enable and the playing flag.
// The state registers double as the result register: a tick is accepted,
// and its result shows on the output in the following cycle.
// Throughput is one tick per cycle while the receiver takes each result: a
// new tick is accepted in the same cycle that the pending result is taken,
// so in_ready_o is high whenever the result slot is empty or being drained.
// When the receiver stalls, the result holds and in_ready_o drops until
// the result is taken.
// Reset clears the counters, the pattern state and the output valid, and
// sets the configuration to play 0, pause 0, repeat 1.
// Configuration writes take effect on the next clock edge; the user must make
// them while no tick is outstanding, which the block itself does not enforce.
`default_nettype none

module beep_pattern_sequencer_unit import bps_pkg::*; #(
  parameter int unsigned TICK_DIVIDE = 10,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 start_beep_i,
  input  wire logic                 stop_beep_i,
  input  wire logic                 clear_counts_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [OUT_W-1:0]          ms_count_o,
  output logic [OUT_W-1:0]          tens_count_o,
  output logic                      tone_on_o,
  output logic                      playing_o
);

  cmd_t cmd;
  logic div_tick;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    cmd.accept = in_valid_i && in_ready_o;
    cmd.start  = start_beep_i;
    cmd.stop   = stop_beep_i;
    cmd.clear  = clear_counts_i;
  end

  // Hold the result until taken; refill on every accepted tick.
  assign out_valid_d = cmd.accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  bps_tick_div #(
    .TICK_DIVIDE (TICK_DIVIDE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .div_tick_o   (div_tick),
    .ms_count_o   (ms_count_o),
    .tens_count_o (tens_count_o)
  );

  bps_pattern u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .div_tick_i (div_tick),
    .tone_on_o  (tone_on_o),
    .playing_o  (playing_o)
  );

endmodule

`default_nettype wire

// ===== src/bps_checker.sv =====
// Port-level assertions for the beep pattern sequencer, bound to the top level.
`default_nettype none

module bps_checker import bps_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             stop_beep_i,
  input wire logic             clear_counts_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [OUT_W-1:0] ms_count_o,
  input wire logic [OUT_W-1:0] tens_count_o,
  input wire logic             tone_on_o,
  input wire logic             playing_o
);

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ms_count_o)
      && $stable(tens_count_o))
    else $error("stalled result changed");

  a_tone_needs_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_on_o |-> playing_o)
    else $error("tone on while not playing");

  a_ms_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> ms_count_o[7:0] ==
      ($past(clear_counts_i) ? 8'd1 : $past(ms_count_o[7:0]) + 8'd1))
    else $error("millisecond count did not advance by one");

  a_tens_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !clear_counts_i |=> tens_count_o[7:0] == $past(tens_count_o[7:0])
      || tens_count_o[7:0] == $past(tens_count_o[7:0]) + 8'd1)
    else $error("divided count jumped");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && stop_beep_i |=> !playing_o && !tone_on_o)
    else $error("stop did not end playback");

endmodule

bind beep_pattern_sequencer_unit bps_checker u_bps_checker (.*);

`default_nettype wire

// ===== verif/tb_beep_pattern_sequencer_unit.sv =====
// Self-checking testbench for the beep pattern sequencer: directed table, then random ticks.
module tb_beep_pattern_sequencer_unit;
  import bps_pkg::*;

  localparam int unsigned TICK_DIV   = 10;
  localparam int unsigned SET_TICKS  = 100;
  localparam int unsigned NUM_SETS   = 9;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned DRAIN_MAX  = 10000;

  typedef struct packed {
    logic [OUT_W-1:0] ms;
    logic [OUT_W-1:0] tens;
    logic             tone;
    logic             playing;
  } readout_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    bit                   go;
    bit                   halt;
    bit                   wipe;
    bit                   pinned;
    readout_t             want;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
  } row_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic                 start_beep_i   = 1'b0;
  logic                 stop_beep_i    = 1'b0;
  logic                 clear_counts_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [OUT_W-1:0]     ms_count_o;
  logic [OUT_W-1:0]     tens_count_o;
  logic                 tone_on_o;
  logic                 playing_o;

  beep_pattern_sequencer_unit #(
    .TICK_DIVIDE(TICK_DIV),
    .COUNT_WIDTH(32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_beep_i   (start_beep_i),
    .stop_beep_i    (stop_beep_i),
    .clear_counts_i (clear_counts_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ms_count_o     (ms_count_o),
    .tens_count_o   (tens_count_o),
    .tone_on_o      (tone_on_o),
    .playing_o      (playing_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Buzzer state as the block should hold it, plus its register copies.
  logic [OUT_W-1:0]   model_ms      = '0;
  logic [OUT_W-1:0]   model_tens    = '0;
  logic [DIV_W-1:0]   model_div     = '0;
  logic [PHASE_W-1:0] model_phase   = '0;
  logic [BEEP_W-1:0]  model_beeps   = '0;
  logic               model_playing = 1'b0;
  logic               model_tone    = 1'b0;
  logic [PHASE_W-1:0] cfg_play      = '0;
  logic [PHASE_W-1:0] cfg_pause     = '0;
  logic [BEEP_W-1:0]  cfg_repeat    = REPEAT_RESET;

  readout_t    readouts_due[$];
  row_t        directed_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned error_count   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned readouts_seen = 0;
  int unsigned tone_seen     = 0;
  int unsigned settings_used = 0;

  function automatic readout_t next_readout(input bit go, input bit halt, input bit wipe);
    readout_t r;
    if (wipe) begin
      model_ms   = '0;
      model_tens = '0;
    end
    if (go) begin
      model_playing = 1'b1;
      model_beeps   = cfg_repeat;
      model_phase   = '0;
      model_tone    = 1'b0;
    end
    if (halt) begin
      model_playing = 1'b0;
      model_tone    = 1'b0;
    end
    model_ms  = model_ms + 1'b1;
    model_div = model_div + 1'b1;
    if (model_div >= TICK_DIV) begin
      model_div  = '0;
      model_tens = model_tens + 1'b1;
      if (model_playing) begin
        if (model_phase != '0) begin
          model_phase = model_phase - 1'b1;
        end else if (model_tone) begin
          // end of a tone phase: count the beep unless endless
          if (model_beeps != ENDLESS_REPEAT) begin
            if (model_beeps != '0) model_beeps = model_beeps - 1'b1;
            if (model_beeps == '0) begin
              model_playing = 1'b0;
              model_tone    = 1'b0;
            end
          end
          if (cfg_pause != '0) begin
            model_phase = cfg_pause;
            model_tone  = 1'b0;
          end else begin
            model_phase = cfg_play;
          end
        end else begin
          model_phase = cfg_play;
          model_tone  = 1'b1;
        end
      end
    end
    r = '{model_ms, model_tens, model_tone, model_playing};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0d, want %0d (after %0d readouts)",
             what, got, want, readouts_seen);
    error_count++;
  endtask

  task automatic add_tick(input bit go, input bit halt, input bit wipe);
    directed_rows.push_back('{ROW_TICK, go, halt, wipe, 1'b0, '0, '0, '0});
  endtask

  task automatic add_pinned(input bit go, input bit halt, input bit wipe, input readout_t want);
    directed_rows.push_back('{ROW_TICK, go, halt, wipe, 1'b1, want, '0, '0});
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    directed_rows.push_back('{ROW_CFG, 1'b0, 1'b0, 1'b0, 1'b0, '0, idx, val});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PLAY_TICKS:   cfg_play   = val[PHASE_W-1:0];
      CFG_PAUSE_TICKS:  cfg_pause  = val[PHASE_W-1:0];
      CFG_REPEAT_COUNT: cfg_repeat = val[BEEP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every readout has come back or the guard runs out, then let the block settle.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (readouts_due.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_tick(input bit go, input bit halt, input bit wipe,
                           input bit pinned, input readout_t want);
    readout_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    start_beep_i   <= go;
    stop_beep_i    <= halt;
    clear_counts_i <= wipe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // advance the model even where the readout is typed in
    predicted = next_readout(go, halt, wipe);
    readouts_due.push_back(pinned ? want : predicted);
    ticks_sent++;
  endtask

  // Result side: random stalls, a counted hold-off on request, and the field checks.
  always @(posedge clk_i) begin : result_side
    readout_t got;
    readout_t want;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
    if (out_valid_o && out_ready_i) begin
      got = '{ms_count_o, tens_count_o, tone_on_o, playing_o};
      if (readouts_due.size() == 0) begin
        report_mismatch("readout with none due (ms_count)", got.ms, '0);
      end else begin
        want = readouts_due.pop_front();
        if (got.ms !== want.ms) report_mismatch("ms_count", got.ms, want.ms);
        if (got.tens !== want.tens) report_mismatch("tens_count", got.tens, want.tens);
        if (got.tone !== want.tone)
          report_mismatch("tone_on", 32'(got.tone), 32'(want.tone));
        if (got.playing !== want.playing)
          report_mismatch("playing", 32'(got.playing), 32'(want.playing));
      end
      readouts_seen++;
      if (got.tone === 1'b1) tone_seen++;
    end
  end

  initial begin : stimulus
    logic [PHASE_W-1:0] set_play  [NUM_SETS] = '{16'd1, 16'd0, 16'd0, 16'd2, 16'd65535,
                                                 16'd1, 16'd0, 16'd3, 16'd1};
    logic [PHASE_W-1:0] set_pause [NUM_SETS] = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd65535,
                                                 16'd0, 16'd1, 16'd0, 16'd2};
    logic [BEEP_W-1:0]  set_repeat[NUM_SETS] = '{8'd3, 8'd0, 8'd255, 8'd2, 8'd255,
                                                 8'd4, 8'd1, 8'd255, 8'd1};
    row_t row;
    bit   go;
    bit   halt;
    bit   wipe;
    int unsigned mode;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: play 0, pause 0, repeat 1.
    add_pinned(1'b0, 1'b0, 1'b0, '{32'd1, 32'd0, 1'b0, 1'b0});
    add_pinned(1'b1, 1'b0, 1'b0, '{32'd2, 32'd0, 1'b0, 1'b1});
    add_pinned(1'b1, 1'b1, 1'b0, '{32'd3, 32'd0, 1'b0, 1'b0});
    add_pinned(1'b0, 1'b0, 1'b1, '{32'd1, 32'd0, 1'b0, 1'b0});
    // Repeat count zero still plays one tone phase.
    add_cfg(CFG_REPEAT_COUNT, 16'd0);
    add_tick(1'b1, 1'b0, 1'b0);
    repeat (14) add_tick(1'b0, 1'b0, 1'b0);
    // Longest phases and endless repeat.
    add_cfg(CFG_PLAY_TICKS, 16'd65535);
    add_cfg(CFG_PAUSE_TICKS, 16'd65535);
    add_cfg(CFG_REPEAT_COUNT, 16'd255);
    add_tick(1'b1, 1'b0, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b0, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_tick(row.go, row.halt, row.wipe, row.pinned, row.want);
      end
    end
    drain();
    settings_used = 3;

    for (int unsigned s = 0; s < NUM_SETS; s++) begin
      mode = s % 4;
      send_idle_pct = (mode == 1) ? 74 : (mode == 3) ? 23 : 0;
      stall_pct     = (mode == 2) ? 74 : (mode == 3) ? 23 : 0;
      write_reg(CFG_PLAY_TICKS, set_play[s]);
      write_reg(CFG_PAUSE_TICKS, set_pause[s]);
      write_reg(CFG_REPEAT_COUNT, {8'd0, set_repeat[s]});
      settings_used++;
      // long receiver hold-off so the block backs up into its input
      if (s == 4) hold_left = HOLD_LEN;
      for (int unsigned k = 0; k < SET_TICKS; k++) begin
        if ($urandom_range(99) == 0) begin
          go   = 1'($urandom_range(1));
          halt = 1'($urandom_range(1));
          wipe = 1'($urandom_range(1));
        end else begin
          go   = (k == 0) || ($urandom_range(199) == 0);
          halt = ($urandom_range(299) == 0);
          wipe = ($urandom_range(149) == 0);
        end
        send_tick(go, halt, wipe, 1'b0, '0);
      end
      drain();
    end

    stall_pct = 0;
    drain();
    repeat (5) @(posedge clk_i);
    if (readouts_due.size() != 0)
      report_mismatch("readouts never delivered", readouts_due.size(), 0);

    $display("covered %0d ticks and %0d checked readouts across %0d register settings",
             ticks_sent, readouts_seen, settings_used);
    $display("tone was on in %0d readouts; %0d mismatches", tone_seen, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/bps_pkg.sv
src/bps_tick_div.sv
src/bps_pattern.sv
src/beep_pattern_sequencer_unit.sv
src/bps_checker.sv
verif/tb_beep_pattern_sequencer_unit.sv
